>>> design/lpd_pkg.sv
// Package for the length-prefixed deframer: widths, reset values, codes,
// parser states and the result record of the parser and result buffer.
// No dependencies.
`timescale 1ns / 1ps

package lpd_pkg;

    localparam int LENGTH_BITS_DEF = 24;
    localparam int PKT_LEN_W       = 24;
    localparam int BYTE_W          = 8;
    localparam int HB_W            = 32;
    localparam int MAX_LEN_W       = 24;
    localparam int CFG_DATA_W      = 32;
    localparam int CFG_INDEX_W     = 1;
    localparam int HDR_BYTES       = 4;
    localparam int MSGNO_BYTES     = 4;

    localparam logic [HB_W-1:0]      HB_RESET      = 32'd100108;
    localparam logic [MAX_LEN_W-1:0] MAX_LEN_RESET = 24'hFF_FFFF;

    // m_tdata layout, lowest bit up
    localparam int TD_BYTE_LSB   = 0;
    localparam int TD_LEN_LSB    = TD_BYTE_LSB + BYTE_W;
    localparam int TD_MARKER_LSB = TD_LEN_LSB + PKT_LEN_W;
    localparam int TD_HB_BIT     = TD_MARKER_LSB + BYTE_W;
    localparam int TD_USED_W     = TD_HB_BIT + 1;
    localparam int TDATA_W       = ((TD_USED_W + 7) / 8) * 8;
    localparam int TUSER_W       = 2;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_HEARTBEAT = 1'b0,
        CFG_MAX_LEN   = 1'b1
    } cfg_index_t;

    typedef enum logic [TUSER_W-1:0] {
        STATUS_OK       = 2'd0,
        STATUS_ZERO_LEN = 2'd1,
        STATUS_TOO_LONG = 2'd2
    } status_t;

    typedef enum logic {
        ST_HEADER  = 1'b0,
        ST_PAYLOAD = 1'b1
    } parse_state_t;

    typedef struct packed {
        logic [HB_W-1:0]      heartbeat;
        logic [MAX_LEN_W-1:0] max_len;
    } cfg_t;

    typedef struct packed {
        logic [BYTE_W-1:0]    payload_byte;
        logic                 last_byte;
        logic [PKT_LEN_W-1:0] packet_length;
        logic [BYTE_W-1:0]    zip_marker;
        logic                 is_heartbeat;
        status_t              status;
    } res_t;

endpackage

>>> design/lpd_cfg.sv
// Configuration registers of the length-prefixed deframer.
// Depends on lpd_pkg.
`timescale 1ns / 1ps

module lpd_cfg import lpd_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    output cfg_t                   cfg
);

    logic [HB_W-1:0]      heartbeat_reg;
    logic [MAX_LEN_W-1:0] max_len_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            heartbeat_reg <= HB_RESET;
            max_len_reg   <= MAX_LEN_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index_t'(cfg_index))
                CFG_HEARTBEAT: heartbeat_reg <= cfg_wdata[HB_W-1:0];
                CFG_MAX_LEN:   max_len_reg   <= cfg_wdata[MAX_LEN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign cfg.heartbeat = heartbeat_reg;
    assign cfg.max_len   = max_len_reg;

endmodule

>>> design/lpd_parser.sv
// Header and payload parser: per-word state update and result formation.
// Depends on lpd_pkg.
`timescale 1ns / 1ps

module lpd_parser import lpd_pkg::*; #(
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_take,
    input  logic [BYTE_W-1:0] in_byte,
    input  cfg_t              cfg,
    output logic              res_valid,
    output res_t              res
);

    localparam int MSG_CNT_W = $clog2(MSGNO_BYTES + 1);
    localparam int HDR_CNT_W = $clog2(HDR_BYTES);

    parse_state_t           state_reg, state_next;
    logic [HDR_CNT_W-1:0]   hdr_cnt_reg, hdr_cnt_next;
    logic [23:0]            hdr_shift_reg, hdr_shift_next;
    logic [LENGTH_BITS-1:0] len_reg, len_next;
    logic [BYTE_W-1:0]      marker_reg, marker_next;
    logic [LENGTH_BITS-1:0] remain_reg, remain_next;
    logic [MSG_CNT_W-1:0]   msg_cnt_reg, msg_cnt_next;
    logic [HB_W-1:0]        msg_shift_reg, msg_shift_next;

    logic [31:0]            hdr_word;
    logic [LENGTH_BITS-1:0] hdr_len;
    logic [BYTE_W-1:0]      hdr_marker;
    logic                   hdr_complete;
    logic                   len_zero;
    logic                   len_over;
    logic                   msg_take;
    logic [MSG_CNT_W-1:0]   msg_cnt_upd;
    logic [HB_W-1:0]        msg_shift_upd;
    logic                   last;
    logic                   hb_hit;

    always_comb begin
        hdr_word      = {hdr_shift_reg, in_byte};
        hdr_len       = hdr_word[LENGTH_BITS-1:0];
        hdr_marker    = hdr_word[31:24];
        hdr_complete  = (hdr_cnt_reg == HDR_CNT_W'(HDR_BYTES - 1));
        len_zero      = (hdr_len == '0);
        len_over      = (PKT_LEN_W'(hdr_len) > cfg.max_len);
        msg_take      = (msg_cnt_reg != MSG_CNT_W'(MSGNO_BYTES));
        msg_cnt_upd   = msg_take ? msg_cnt_reg + MSG_CNT_W'(1) : msg_cnt_reg;
        msg_shift_upd = msg_take ? {msg_shift_reg[HB_W-BYTE_W-1:0], in_byte} : msg_shift_reg;
        last          = (remain_reg == LENGTH_BITS'(1));
        hb_hit        = last && (msg_cnt_upd == MSG_CNT_W'(MSGNO_BYTES))
                        && (msg_shift_upd == cfg.heartbeat);
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_HEADER: begin
                if (in_take && hdr_complete && !len_zero && !len_over) state_next = ST_PAYLOAD;
            end
            ST_PAYLOAD: begin
                if (in_take && last) state_next = ST_HEADER;
            end
            default: state_next = ST_HEADER;
        endcase
    end

    always_comb begin
        res_valid         = 1'b0;
        res.payload_byte  = '0;
        res.last_byte     = 1'b0;
        res.packet_length = '0;
        res.zip_marker    = hdr_marker;
        res.is_heartbeat  = 1'b0;
        res.status        = STATUS_OK;
        unique case (state_reg)
            ST_HEADER: begin
                if (hdr_complete && len_zero) begin
                    res_valid  = in_take;
                    res.status = STATUS_ZERO_LEN;
                end else if (hdr_complete && len_over) begin
                    res_valid         = in_take;
                    res.packet_length = PKT_LEN_W'(hdr_len);
                    res.status        = STATUS_TOO_LONG;
                end
            end
            ST_PAYLOAD: begin
                res_valid         = in_take;
                res.payload_byte  = in_byte;
                res.last_byte     = last;
                res.packet_length = PKT_LEN_W'(len_reg);
                res.zip_marker    = marker_reg;
                res.is_heartbeat  = hb_hit;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        hdr_cnt_next   = hdr_cnt_reg;
        hdr_shift_next = hdr_shift_reg;
        len_next       = len_reg;
        marker_next    = marker_reg;
        remain_next    = remain_reg;
        msg_cnt_next   = msg_cnt_reg;
        msg_shift_next = msg_shift_reg;
        if (in_take) begin
            if (state_reg == ST_HEADER) begin
                hdr_shift_next = hdr_word[23:0];
                hdr_cnt_next   = hdr_complete ? '0 : hdr_cnt_reg + HDR_CNT_W'(1);
                if (hdr_complete) begin
                    len_next       = hdr_len;
                    marker_next    = hdr_marker;
                    remain_next    = hdr_len;
                    msg_cnt_next   = '0;
                    msg_shift_next = '0;
                end
            end else begin
                remain_next    = remain_reg - LENGTH_BITS'(1);
                msg_cnt_next   = msg_cnt_upd;
                msg_shift_next = msg_shift_upd;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_HEADER;
            hdr_cnt_reg <= '0;
            msg_cnt_reg <= '0;
        end else begin
            state_reg   <= state_next;
            hdr_cnt_reg <= hdr_cnt_next;
            msg_cnt_reg <= msg_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        hdr_shift_reg <= hdr_shift_next;
        len_reg       <= len_next;
        marker_reg    <= marker_next;
        remain_reg    <= remain_next;
        msg_shift_reg <= msg_shift_next;
    end

endmodule

>>> design/lpd_out_buf.sv
// Result register with a skid stage, so the input side keeps flowing while
// a result waits. Depends on lpd_pkg.
`timescale 1ns / 1ps

module lpd_out_buf import lpd_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  res_t push_res,
    output logic in_ready,
    output logic out_valid,
    input  logic out_ready,
    output res_t out_res
);

    logic out_valid_reg, out_valid_next;
    logic skid_valid_reg, skid_valid_next;
    res_t out_res_reg, out_res_next;
    res_t skid_res_reg, skid_res_next;
    logic pop;

    always_comb begin
        pop             = out_valid_reg && out_ready;
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_res_next    = out_res_reg;
        skid_res_next   = skid_res_reg;
        if (skid_valid_reg) begin
            if (pop) begin
                out_res_next    = skid_res_reg;
                skid_valid_next = 1'b0;
            end
        end else if (push) begin
            if (!out_valid_reg || pop) begin
                out_res_next   = push_res;
                out_valid_next = 1'b1;
            end else begin
                skid_res_next   = push_res;
                skid_valid_next = 1'b1;
            end
        end else if (pop) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_res_reg  <= out_res_next;
        skid_res_reg <= skid_res_next;
    end

    assign in_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;

endmodule

>>> design/length_prefixed_deframer_core.sv
// Top level of the length-prefixed deframer: configuration registers,
// parser and result buffer. Depends on lpd_pkg, lpd_cfg, lpd_parser, lpd_out_buf.
//
//  channel  | direction | content
//  ---------+-----------+-----------------------------------------------------
//  s_       | in        | one received byte per word
//  m_       | out       | payload byte or error word, tagged with length/marker
//  cfg_     | in        | register write: 0 heartbeat number, 1 max length
//
// One word per cycle in while s_tready is high; each result is registered.
// Header words give no result except the fourth, and only on a length error.
// A two-deep result buffer keeps s_tready high while its skid register is empty.
// aresetn is synchronous; after reset the parser hunts for a header.
`timescale 1ns / 1ps

module length_prefixed_deframer_core import lpd_pkg::*; #(
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [BYTE_W-1:0]      s_tdata,   // rx_byte
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // payload_byte, packet_length, zip_marker, is_heartbeat, zero fill
    output logic [TDATA_W-1:0]     m_tdata,
    output logic                   m_tlast,
    output logic [TUSER_W-1:0]     m_tuser,   // status
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

    cfg_t cfg;
    logic in_take;
    logic res_valid;
    res_t res;
    res_t out_res;

    assign in_take = s_tvalid && s_tready;

    lpd_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    lpd_parser #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_take   (in_take),
        .in_byte   (s_tdata),
        .cfg       (cfg),
        .res_valid (res_valid),
        .res       (res)
    );

    lpd_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (res_valid),
        .push_res  (res),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (out_res)
    );

    assign m_tdata = TDATA_W'({out_res.is_heartbeat, out_res.zip_marker,
                               out_res.packet_length, out_res.payload_byte});
    assign m_tlast = out_res.last_byte;
    assign m_tuser = out_res.status;

endmodule

>>> design/lpd_checker.sv
// Port-level checks on the length-prefixed deframer, bound to the top level.
// Depends on lpd_pkg and length_prefixed_deframer_core.
`timescale 1ns / 1ps

module lpd_checker import lpd_pkg::*; (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [TDATA_W-1:0]   m_tdata,
    input logic                 m_tlast,
    input logic [TUSER_W-1:0]   m_tuser
);

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    a_error_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != STATUS_OK |->
            m_tdata[TD_LEN_LSB-1:TD_BYTE_LSB] == '0 && !m_tlast && !m_tdata[TD_HB_BIT])
        else $error("error word carries payload fields");

    a_zero_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == STATUS_ZERO_LEN |->
            m_tdata[TD_MARKER_LSB-1:TD_LEN_LSB] == '0)
        else $error("zero length error with nonzero length");

    a_hb_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[TD_HB_BIT] |-> m_tlast)
        else $error("heartbeat flag off the last byte");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind length_prefixed_deframer_core lpd_checker u_lpd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);
